>>> rtl/core/md5_pkg.sv
package md5_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_CHAIN,
        ST_OUT
    } state_t;

    localparam int unsigned WordW = 32;
    localparam int unsigned StepW = 6;
    localparam int unsigned FillW = 4;
    localparam int unsigned LenW  = 64;

    localparam logic [WordW-1:0] InitA = 32'h67452301;
    localparam logic [WordW-1:0] InitB = 32'hefcdab89;
    localparam logic [WordW-1:0] InitC = 32'h98badcfe;
    localparam logic [WordW-1:0] InitD = 32'h10325476;

    localparam logic [WordW-1:0] PadByte   = 32'h00000080;
    localparam logic [FillW-1:0] LenLoSlot = 4'd14;
    localparam logic [FillW-1:0] LastSlot  = 4'd15;
    localparam logic [StepW-1:0] LastStep  = 6'd63;

    localparam logic [WordW-1:0] StepConst [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amount for a step: picked by round group and the step's low two bits.
    function automatic logic [4:0] rot_amount(input logic [StepW-1:0] step);
        logic [4:0] amt;
        case ({step[5:4], step[1:0]})
            4'b0000: amt = 5'd7;
            4'b0001: amt = 5'd12;
            4'b0010: amt = 5'd17;
            4'b0011: amt = 5'd22;
            4'b0100: amt = 5'd5;
            4'b0101: amt = 5'd9;
            4'b0110: amt = 5'd14;
            4'b0111: amt = 5'd20;
            4'b1000: amt = 5'd4;
            4'b1001: amt = 5'd11;
            4'b1010: amt = 5'd16;
            4'b1011: amt = 5'd23;
            4'b1100: amt = 5'd6;
            4'b1101: amt = 5'd10;
            4'b1110: amt = 5'd15;
            default: amt = 5'd21;
        endcase
        return amt;
    endfunction

    // Message word used by a step; all products are taken modulo 16.
    function automatic logic [FillW-1:0] msg_index(input logic [StepW-1:0] step);
        logic [FillW-1:0] i;
        logic [FillW-1:0] g;
        i = step[3:0];
        case (step[5:4])
            2'd0:    g = i;
            2'd1:    g = FillW'({i, 2'b00} + i + 4'd1);
            2'd2:    g = FillW'({i, 1'b0} + i + 4'd5);
            default: g = FillW'({i, 3'b000} - i);
        endcase
        return g;
    endfunction

endpackage

>>> rtl/core/md5_hash_engine.sv
// Channel  Handshake               Payload
// input    in_valid / in_ready     data_word, valid_bytes, final_word
// output   out_valid / out_ready   digest_word, word_index, digest_last
//
// A word that does not complete a block is written straight into the block buffer.
// A word that completes a block is written; 64 rounds then run on the single round
// unit, and a step adds the working words into the chaining words. A final word
// is followed by one padding word per cycle outside compressions, one or two
// compressions, and four digest transactions, one per cycle while out_ready is high.
// in_ready is high only while idle; reset restores the MD5 initial chaining words.
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        final_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        digest_last
);

    state_t state_reg, state_next;

    logic [WordW-1:0] chain_reg [4];
    logic [WordW-1:0] chain_next [4];
    logic [WordW-1:0] work_reg [4];
    logic [WordW-1:0] work_next [4];
    logic [WordW-1:0] block_mem [16];

    logic [FillW-1:0] fill_reg, fill_next;
    logic [LenW-1:0]  bits_reg, bits_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [1:0]       idx_reg, idx_next;
    logic             fin_reg, fin_next;
    logic             pad80_reg, pad80_next;
    logic             lo_done_reg, lo_done_next;
    logic             hi_done_reg, hi_done_next;

    logic             wr_en;
    logic [WordW-1:0] wr_word;
    logic [2:0]       nbytes;
    logic [WordW-1:0] last_word;

    // Round datapath
    logic [WordW-1:0] f_val;
    logic [WordW-1:0] t_val;
    logic [63:0]      rot_full;
    logic [WordW-1:0] new_b;

    always_comb begin
        nbytes = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nbytes)
            3'd0:    last_word = PadByte;
            3'd1:    last_word = {16'h0000, 8'h80, data_word[7:0]};
            3'd2:    last_word = {8'h00, 8'h80, data_word[15:0]};
            3'd3:    last_word = {8'h80, data_word[23:0]};
            default: last_word = data_word;
        endcase
    end

    always_comb begin
        case (step_reg[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        t_val    = work_reg[0] + f_val + StepConst[step_reg] + block_mem[msg_index(step_reg)];
        rot_full = {t_val, t_val} << rot_amount(step_reg);
        new_b    = work_reg[1] + rot_full[63:32];
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        bits_next    = bits_reg;
        step_next    = step_reg;
        idx_next     = idx_reg;
        fin_next     = fin_reg;
        pad80_next   = pad80_reg;
        lo_done_next = lo_done_reg;
        hi_done_next = hi_done_reg;
        chain_next   = chain_reg;
        work_next    = work_reg;
        wr_en        = 1'b0;
        wr_word      = data_word;
        in_ready     = 1'b0;
        out_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 4'd1;
                    if (!final_word) begin
                        wr_word   = data_word;
                        bits_next = bits_reg + LenW'(32);
                    end else begin
                        wr_word    = last_word;
                        bits_next  = bits_reg + LenW'({nbytes, 3'b000});
                        fin_next   = 1'b1;
                        pad80_next = (nbytes == 3'd4);
                    end
                    if (fill_reg == LastSlot) begin
                        work_next  = chain_reg;
                        state_next = ST_ROUND;
                    end else if (final_word) begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                wr_en     = 1'b1;
                fill_next = fill_reg + 4'd1;
                if (pad80_reg) begin
                    wr_word    = PadByte;
                    pad80_next = 1'b0;
                end else if (fill_reg == LenLoSlot) begin
                    wr_word      = bits_reg[31:0];
                    lo_done_next = 1'b1;
                end else if (lo_done_reg) begin
                    wr_word      = bits_reg[63:32];
                    hi_done_next = 1'b1;
                end else begin
                    wr_word = '0;
                end
                if (fill_reg == LastSlot) begin
                    work_next  = chain_reg;
                    state_next = ST_ROUND;
                end
            end

            ST_ROUND: begin
                work_next[0] = work_reg[3];
                work_next[1] = new_b;
                work_next[2] = work_reg[1];
                work_next[3] = work_reg[2];
                step_next    = step_reg + 6'd1;
                if (step_reg == LastStep) begin
                    state_next = ST_CHAIN;
                end
            end

            ST_CHAIN: begin
                for (int i = 0; i < 4; i++) begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
                if (hi_done_reg) begin
                    idx_next   = 2'd0;
                    state_next = ST_OUT;
                end else if (fin_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        chain_next   = '{InitA, InitB, InitC, InitD};
                        fill_next    = '0;
                        bits_next    = '0;
                        fin_next     = 1'b0;
                        pad80_next   = 1'b0;
                        lo_done_next = 1'b0;
                        hi_done_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chain_reg   <= '{InitA, InitB, InitC, InitD};
            work_reg    <= '{'0, '0, '0, '0};
            fill_reg    <= '0;
            bits_reg    <= '0;
            step_reg    <= '0;
            idx_reg     <= '0;
            fin_reg     <= 1'b0;
            pad80_reg   <= 1'b0;
            lo_done_reg <= 1'b0;
            hi_done_reg <= 1'b0;
        end else begin
            chain_reg   <= chain_next;
            work_reg    <= work_next;
            fill_reg    <= fill_next;
            bits_reg    <= bits_next;
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            fin_reg     <= fin_next;
            pad80_reg   <= pad80_next;
            lo_done_reg <= lo_done_next;
            hi_done_reg <= hi_done_next;
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            block_mem[fill_reg] <= wr_word;
        end
    end

    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign digest_last = (idx_reg == 2'd3);

    // The two channels are never open at the same time.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output open together");

    // A compression always starts on a full block.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ROUND && state_next == ST_ROUND) |-> (fill_next == '0))
        else $error("compression started on a partial block");

    // The rounds run uninterrupted until the last step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && step_reg != LastStep) |=> (state_reg == ST_ROUND))
        else $error("round sequence broken");

    // After the last digest word the engine is idle with a fresh length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && digest_last) |=> (in_ready && bits_reg == '0))
        else $error("engine not cleared after digest");

endmodule
